// ===== design/qau_pkg.sv =====
// ---------------------------------------------------------------------------
// qau_pkg: shared definitions for the quaternion arithmetic unit
// Operation codes, default widths, the pipeline enable bundle and the sign
// pattern of the Hamilton product.
// ---------------------------------------------------------------------------
package qau_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COMP_WIDTH_DEF = 32;
    localparam int NUM_COMP       = 4;

    typedef enum logic [2:0] {
        FUNC_ADD  = 3'd0,
        FUNC_SUB  = 3'd1,
        FUNC_MUL  = 3'd2,
        FUNC_CONJ = 3'd3,
        FUNC_VMUL = 3'd4
    } qau_func_t;

    // Load enables of the four register stages, derived from the valid bits.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } qau_pipe_en_t;

    // Component c of A*B sums the products a[k]*b[c^k]; bit k set means that
    // product is subtracted.
    localparam logic [3:0] PROD_NEG [NUM_COMP] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

// ===== design/qau_mult.sv =====
// ---------------------------------------------------------------------------
// qau_mult: two-stage signed multiplier with fraction shift
// The operands are split into halves; the four partial products are
// registered, then recombined and shifted right arithmetically.
// ---------------------------------------------------------------------------
module qau_mult #(
    parameter int W    = qau_pkg::COMP_WIDTH_DEF,
    parameter int FRAC = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  qau_pkg::qau_pipe_en_t en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    import qau_pkg::*;

    localparam int LO_W = W / 2;
    localparam int HI_W = W - LO_W;
    localparam int PW   = 2 * W;

    logic signed [LO_W:0]          a_lo, b_lo;
    logic signed [HI_W-1:0]        a_hi, b_hi;
    logic signed [2*LO_W+1:0]      ll_next, ll_reg;
    logic signed [HI_W+LO_W:0]     hl_next, hl_reg, lh_next, lh_reg;
    logic signed [2*HI_W-1:0]      hh_next, hh_reg;
    logic signed [PW-1:0]          full;
    logic signed [PW-1:0]          p_next, p_reg;

    // Low halves are unsigned, so they get a zero sign bit.
    assign a_lo = $signed({1'b0, a[LO_W-1:0]});
    assign b_lo = $signed({1'b0, b[LO_W-1:0]});
    assign a_hi = a[W-1:LO_W];
    assign b_hi = b[W-1:LO_W];

    assign ll_next = a_lo * b_lo;
    assign hl_next = a_hi * b_lo;
    assign lh_next = a_lo * b_hi;
    assign hh_next = a_hi * b_hi;

    always_ff @(posedge aclk) begin
        if (en.en1) begin
            ll_reg <= ll_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            hh_reg <= hh_next;
        end
    end

    // The true product fits in PW bits, so wrap-around in the terms is harmless.
    assign full = (PW'(hh_reg) <<< (2 * LO_W)) + (PW'(hl_reg) <<< LO_W)
                + (PW'(lh_reg) <<< LO_W) + PW'(ll_reg);
    assign p_next = full >>> FRAC;

    always_ff @(posedge aclk) begin
        if (en.en2) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== design/qau_accum.sv =====
// ---------------------------------------------------------------------------
// qau_accum: signed four-term sum with saturation
// Adds four signed terms in two registered stages and clamps the total to
// the component range; the second register is the output register.
// ---------------------------------------------------------------------------
module qau_accum #(
    parameter int W = qau_pkg::COMP_WIDTH_DEF
) (
    input  logic                  aclk,
    input  qau_pkg::qau_pipe_en_t en,
    input  logic signed [2*W-1:0] term [qau_pkg::NUM_COMP],
    input  logic [3:0]            neg,
    output logic signed [W-1:0]   r
);
    import qau_pkg::*;

    localparam int TW = 2 * W;
    localparam int PW = TW + 2;
    localparam int SW = TW + 3;
    localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    logic signed [PW-1:0] ext [NUM_COMP];
    logic signed [PW-1:0] pair_next [2];
    logic signed [PW-1:0] pair_reg [2];
    logic signed [SW-1:0] total;
    logic signed [W-1:0]  r_next, r_reg;

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            ext[k] = neg[k] ? -PW'(term[k]) : PW'(term[k]);
        end
        pair_next[0] = ext[0] + ext[1];
        pair_next[1] = ext[2] + ext[3];
    end

    always_ff @(posedge aclk) begin
        if (en.en3) begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
    end

    assign total = SW'(pair_reg[0]) + SW'(pair_reg[1]);

    always_comb begin
        if (total > SAT_MAX) begin
            r_next = SAT_MAX[W-1:0];
        end else if (total < SAT_MIN) begin
            r_next = SAT_MIN[W-1:0];
        end else begin
            r_next = total[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.en4) begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// ===== design/quaternion_arith_unit_top.sv =====
// ---------------------------------------------------------------------------
// quaternion_arith_unit_top: pipelined quaternion arithmetic unit
// Add, subtract, conjugate, Hamilton product and product with a pure vector
// on fixed-point quaternions, with saturated components.
// ---------------------------------------------------------------------------
//  Channel | Dir | Handshake          | Payload
//  s_      | in  | s_valid / s_ready  | s_func, s_a_w..s_a_z, s_b_w..s_b_z
//  m_      | out | m_valid / m_ready  | m_r_w, m_r_x, m_r_y, m_r_z
//
//  One word is accepted per cycle while s_ready is high; each word passes
//  four register stages: two in the split multipliers, two in the adders.
//  Reset clears the valid bits of the four stages only.
//  Each stage loads whenever it is empty or the stage after it moves, so a
//  stall at m_ready fills bubbles first and loses or repeats nothing.
// ---------------------------------------------------------------------------
module quaternion_arith_unit_top #(
    parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF,
    parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_func,
    input  logic signed [COMP_WIDTH-1:0] s_a_w,
    input  logic signed [COMP_WIDTH-1:0] s_a_x,
    input  logic signed [COMP_WIDTH-1:0] s_a_y,
    input  logic signed [COMP_WIDTH-1:0] s_a_z,
    input  logic signed [COMP_WIDTH-1:0] s_b_w,
    input  logic signed [COMP_WIDTH-1:0] s_b_x,
    input  logic signed [COMP_WIDTH-1:0] s_b_y,
    input  logic signed [COMP_WIDTH-1:0] s_b_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COMP_WIDTH-1:0] m_r_w,
    output logic signed [COMP_WIDTH-1:0] m_r_x,
    output logic signed [COMP_WIDTH-1:0] m_r_y,
    output logic signed [COMP_WIDTH-1:0] m_r_z
);
    import qau_pkg::*;

    localparam int W  = COMP_WIDTH;
    localparam int TW = 2 * W;

    qau_pipe_en_t        en;
    logic                v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic [2:0]          func1_reg, func2_reg;
    logic signed [W-1:0] a_in [NUM_COMP];
    logic signed [W-1:0] b_in [NUM_COMP];
    logic signed [W-1:0] a1_reg [NUM_COMP];
    logic signed [W-1:0] b1_reg [NUM_COMP];
    logic signed [W-1:0] a2_reg [NUM_COMP];
    logic signed [W-1:0] b2_reg [NUM_COMP];
    logic signed [TW-1:0] prod [NUM_COMP][NUM_COMP];
    logic signed [TW-1:0] term [NUM_COMP][NUM_COMP];
    logic [3:0]           neg_sel [NUM_COMP];
    logic signed [W-1:0]  r_out [NUM_COMP];

    assign en.en4  = !m_valid_reg || m_ready;
    assign en.en3  = !v3_reg || en.en4;
    assign en.en2  = !v2_reg || en.en3;
    assign en.en1  = !v1_reg || en.en2;
    assign s_ready = en.en1;

    // The vector product treats the scalar of B as zero.
    assign a_in[0] = s_a_w;
    assign a_in[1] = s_a_x;
    assign a_in[2] = s_a_y;
    assign a_in[3] = s_a_z;
    assign b_in[0] = (s_func == FUNC_VMUL) ? '0 : s_b_w;
    assign b_in[1] = s_b_x;
    assign b_in[2] = s_b_y;
    assign b_in[3] = s_b_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en.en1) v1_reg      <= s_valid;
            if (en.en2) v2_reg      <= v1_reg;
            if (en.en3) v3_reg      <= v2_reg;
            if (en.en4) m_valid_reg <= v3_reg;
        end
    end

    // Operands for the linear operations travel alongside the multipliers.
    always_ff @(posedge aclk) begin
        if (en.en1) begin
            func1_reg <= s_func;
            a1_reg    <= a_in;
            b1_reg    <= b_in;
        end
        if (en.en2) begin
            func2_reg <= func1_reg;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
        end
    end

    for (genvar i = 0; i < NUM_COMP; i++) begin : g_row
        for (genvar j = 0; j < NUM_COMP; j++) begin : g_col
            qau_mult #(
                .W    (W),
                .FRAC (FRAC_BITS)
            ) u_mult (
                .aclk (aclk),
                .en   (en),
                .a    (a_in[i]),
                .b    (b_in[j]),
                .p    (prod[i][j])
            );
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            for (int k = 0; k < NUM_COMP; k++) begin
                term[c][k] = '0;
            end
            neg_sel[c] = 4'b0000;
        end
        unique case (func2_reg) inside
            FUNC_ADD: begin
                for (int c = 0; c < NUM_COMP; c++) begin
                    term[c][0] = TW'(a2_reg[c]);
                    term[c][1] = TW'(b2_reg[c]);
                end
            end
            FUNC_SUB: begin
                for (int c = 0; c < NUM_COMP; c++) begin
                    term[c][0] = TW'(a2_reg[c]);
                    term[c][1] = TW'(b2_reg[c]);
                    neg_sel[c] = 4'b0010;
                end
            end
            FUNC_CONJ: begin
                for (int c = 0; c < NUM_COMP; c++) begin
                    term[c][0] = TW'(a2_reg[c]);
                    neg_sel[c] = {3'b000, (c != 0)};
                end
            end
            FUNC_MUL, FUNC_VMUL: begin
                for (int c = 0; c < NUM_COMP; c++) begin
                    for (int k = 0; k < NUM_COMP; k++) begin
                        term[c][k] = prod[k][2'(c) ^ 2'(k)];
                    end
                    neg_sel[c] = PROD_NEG[c];
                end
            end
            default: begin
                // Unused codes leave every term at zero.
            end
        endcase
    end

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp
        qau_accum #(
            .W (W)
        ) u_accum (
            .aclk (aclk),
            .en   (en),
            .term (term[c]),
            .neg  (neg_sel[c]),
            .r    (r_out[c])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_r_w   = r_out[0];
    assign m_r_x   = r_out[1];
    assign m_r_y   = r_out[2];
    assign m_r_z   = r_out[3];

    // An accepted word always lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted word missing from stage one");

    // A held second stage keeps its word and operation code.
    a_stage2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !en.en2) |=> (v2_reg && $stable(func2_reg)))
        else $error("stalled word in stage two was lost or altered");

    // With the output register empty the pipeline can always take a word.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with an empty output register");

    // A new result comes only from a word that sat in the third stage.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v3_reg))
        else $error("result appeared without a word in stage three");

endmodule

// ===== bench/quat_checker.sv =====
// ---------------------------------------------------------------------------
// quat_checker: result predictor and comparator for the quaternion unit
// Watches both channels at the rising clock edge, works out the quaternion
// expected for every input word taken, and compares every result word with
// the oldest one still outstanding.
// ---------------------------------------------------------------------------
module quat_checker #(
    parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF,
    parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [2:0]                   s_func,
    input  logic signed [COMP_WIDTH-1:0] s_a_w,
    input  logic signed [COMP_WIDTH-1:0] s_a_x,
    input  logic signed [COMP_WIDTH-1:0] s_a_y,
    input  logic signed [COMP_WIDTH-1:0] s_a_z,
    input  logic signed [COMP_WIDTH-1:0] s_b_w,
    input  logic signed [COMP_WIDTH-1:0] s_b_x,
    input  logic signed [COMP_WIDTH-1:0] s_b_y,
    input  logic signed [COMP_WIDTH-1:0] s_b_z,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [COMP_WIDTH-1:0] m_r_w,
    input  logic signed [COMP_WIDTH-1:0] m_r_x,
    input  logic signed [COMP_WIDTH-1:0] m_r_y,
    input  logic signed [COMP_WIDTH-1:0] m_r_z,
    output int                           fails,
    output int                           outstanding,
    output int                           results
);
    import qau_pkg::*;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] w;
        logic signed [COMP_WIDTH-1:0] x;
        logic signed [COMP_WIDTH-1:0] y;
        logic signed [COMP_WIDTH-1:0] z;
    } quat_t;

    localparam longint COMP_MAX = (64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1;
    localparam longint COMP_MIN = -COMP_MAX - 64'sd1;

    quat_t expected_q[$];
    int    fail_cnt   = 0;
    int    result_cnt = 0;
    int    queued     = 0;

    assign fails       = fail_cnt;
    assign outstanding = queued;
    assign results     = result_cnt;

    // Fixed-point product, floored by the arithmetic shift.
    function automatic longint fx_mul(longint p, longint q);
        return (p * q) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [COMP_WIDTH-1:0] clamp(longint v);
        if (v > COMP_MAX)
            return COMP_MAX[COMP_WIDTH-1:0];
        if (v < COMP_MIN)
            return COMP_MIN[COMP_WIDTH-1:0];
        return v[COMP_WIDTH-1:0];
    endfunction

    function automatic quat_t quat_result(logic [2:0] op, quat_t a, quat_t b);
        longint aw, ax, ay, az, bw, bx, by, bz;
        longint rw, rx, ry, rz;
        quat_t  r;
        aw = a.w; ax = a.x; ay = a.y; az = a.z;
        bw = b.w; bx = b.x; by = b.y; bz = b.z;
        rw = 0; rx = 0; ry = 0; rz = 0;
        case (op)
            FUNC_ADD: begin
                rw = aw + bw; rx = ax + bx; ry = ay + by; rz = az + bz;
            end
            FUNC_SUB: begin
                rw = aw - bw; rx = ax - bx; ry = ay - by; rz = az - bz;
            end
            FUNC_CONJ: begin
                rw = aw; rx = -ax; ry = -ay; rz = -az;
            end
            FUNC_MUL, FUNC_VMUL: begin
                // The vector form drops the scalar of B before multiplying.
                if (op == FUNC_VMUL)
                    bw = 0;
                rw = fx_mul(aw, bw) - fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz);
                rx = fx_mul(aw, bx) + fx_mul(ax, bw) + fx_mul(ay, bz) - fx_mul(az, by);
                ry = fx_mul(aw, by) - fx_mul(ax, bz) + fx_mul(ay, bw) + fx_mul(az, bx);
                rz = fx_mul(aw, bz) + fx_mul(ax, by) - fx_mul(ay, bx) + fx_mul(az, bw);
            end
            default: ;
        endcase
        r.w = clamp(rw);
        r.x = clamp(rx);
        r.y = clamp(ry);
        r.z = clamp(rz);
        return r;
    endfunction

    task automatic check_part(input string part, input logic signed [COMP_WIDTH-1:0] want,
                              input logic signed [COMP_WIDTH-1:0] got);
        if (got !== want) begin
            fail_cnt++;
            $display("%0t: mismatch on m_r_%s, expected %0d, got %0d", $time, part, want, got);
        end
    endtask

    always @(posedge aclk) begin
        quat_t want;
        if (aresetn) begin
            // Retire first, so a word taken at the same edge is never matched.
            if (m_valid && m_ready) begin
                result_cnt++;
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result word with nothing expected, got %0d %0d %0d %0d",
                             $time, m_r_w, m_r_x, m_r_y, m_r_z);
                end else begin
                    want = expected_q.pop_front();
                    check_part("w", want.w, m_r_w);
                    check_part("x", want.x, m_r_x);
                    check_part("y", want.y, m_r_y);
                    check_part("z", want.z, m_r_z);
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(quat_result(s_func, {s_a_w, s_a_x, s_a_y, s_a_z},
                                                 {s_b_w, s_b_x, s_b_y, s_b_z}));
        end
        queued = expected_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the quaternion arithmetic unit
// Offers a directed set of words covering saturation, unit products and the
// unused codes, then random words, with random idling on both channels and
// one long receiver hold-off that backs the pipeline up.
// ---------------------------------------------------------------------------
module tb;
    import qau_pkg::*;

    localparam int W = COMP_WIDTH_DEF;

    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam logic signed [W-1:0] C_MAX = 32'sh7fff_ffff;
    localparam logic signed [W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [W-1:0] Q_ONE = 32'sh0001_0000;

    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [2:0]          s_func;
    logic signed [W-1:0] s_a_w, s_a_x, s_a_y, s_a_z;
    logic signed [W-1:0] s_b_w, s_b_x, s_b_y, s_b_z;
    logic                m_valid;
    logic                m_ready;
    logic signed [W-1:0] m_r_w, m_r_x, m_r_y, m_r_z;

    int fails;
    int outstanding;
    int results;
    int op_count[8];
    int calm_words = 0;
    bit settle     = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    quaternion_arith_unit_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .s_a_w   (s_a_w),
        .s_a_x   (s_a_x),
        .s_a_y   (s_a_y),
        .s_a_z   (s_a_z),
        .s_b_w   (s_b_w),
        .s_b_x   (s_b_x),
        .s_b_y   (s_b_y),
        .s_b_z   (s_b_z),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_r_w   (m_r_w),
        .m_r_x   (m_r_x),
        .m_r_y   (m_r_y),
        .m_r_z   (m_r_z)
    );

    quat_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_a_w       (s_a_w),
        .s_a_x       (s_a_x),
        .s_a_y       (s_a_y),
        .s_a_z       (s_a_z),
        .s_b_w       (s_b_w),
        .s_b_x       (s_b_x),
        .s_b_y       (s_b_y),
        .s_b_z       (s_b_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_r_w       (m_r_w),
        .m_r_x       (m_r_x),
        .m_r_y       (m_r_y),
        .m_r_z       (m_r_z),
        .fails       (fails),
        .outstanding (outstanding),
        .results     (results)
    );

    // Offers one word and returns once it has been taken.
    task automatic offer(input logic [2:0] op,
                         input logic signed [W-1:0] aw, ax, ay, az, bw, bx, by, bz);
        if (!settle && calm_words == 0 && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        if (calm_words > 0)
            calm_words--;
        else if ($urandom_range(0, 49) == 0)
            calm_words = 40;
        s_valid <= 1'b1;
        s_func  <= op;
        s_a_w   <= aw;
        s_a_x   <= ax;
        s_a_y   <= ay;
        s_a_z   <= az;
        s_b_w   <= bw;
        s_b_x   <= bx;
        s_b_y   <= by;
        s_b_z   <= bz;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        op_count[op]++;
    endtask

    // Mostly values of a few units, where products stay in range, with
    // full-width noise and the extremes mixed in.
    function automatic logic signed [W-1:0] pick_comp();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = C_MAX;
                    1: v = C_MIN;
                    2: v = '0;
                    3: v = -1;
                    4: v = Q_ONE;
                    default: v = -Q_ONE;
                endcase
            end
            1, 2, 3: v = $urandom;
            default: begin
                v = $urandom_range(0, 32'h0008_0000);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Receiver: a long hold-off first, while the sender keeps offering, then
    // random stall bursts with calm stretches in between.
    initial begin
        int calm;
        calm = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        repeat (HOLD_CYCLES) @(posedge aclk);
        forever begin
            if (!settle && calm == 0 && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 59) == 0)
                calm = 60;
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        logic [2:0] op;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_func  <= FUNC_ADD;
        s_a_w   <= '0;
        s_a_x   <= '0;
        s_a_y   <= '0;
        s_a_z   <= '0;
        s_b_w   <= '0;
        s_b_x   <= '0;
        s_b_y   <= '0;
        s_b_z   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sums and differences that run off both ends of the range.
        offer(FUNC_ADD, C_MAX, C_MIN, Q_ONE, -1, C_MAX, C_MIN, -Q_ONE, 1);
        offer(FUNC_ADD, '0, '0, '0, '0, '0, '0, '0, '0);
        offer(FUNC_SUB, C_MIN, C_MAX, '0, -1, C_MAX, C_MIN, C_MIN, C_MAX);
        offer(FUNC_SUB, C_MAX, -1, 5, C_MIN, -1, C_MAX, 5, 1);
        // Unit quaternions: identity, the i, j, k cycle and one product the other way round.
        offer(FUNC_MUL, Q_ONE, '0, '0, '0, 32'sh0003_8000, -32'sh0001_4000, 7, C_MIN);
        offer(FUNC_MUL, '0, Q_ONE, '0, '0, '0, '0, Q_ONE, '0);
        offer(FUNC_MUL, '0, '0, Q_ONE, '0, '0, '0, '0, Q_ONE);
        offer(FUNC_MUL, '0, '0, '0, Q_ONE, '0, Q_ONE, '0, '0);
        offer(FUNC_MUL, '0, '0, Q_ONE, '0, '0, Q_ONE, '0, '0);
        // Products far out of range, and ones that floor just below zero.
        offer(FUNC_MUL, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        offer(FUNC_MUL, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        offer(FUNC_MUL, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN);
        offer(FUNC_MUL, -1, '0, '0, '0, 1, '0, '0, '0);
        offer(FUNC_MUL, 1, -1, 1, -1, 1, 1, 1, 1);
        // Negating the most negative component saturates upwards.
        offer(FUNC_CONJ, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, 3, -3, 9);
        offer(FUNC_CONJ, C_MAX, -1, 1, '0, '0, '0, '0, '0);
        // The vector product must ignore a non-zero scalar in B.
        offer(FUNC_VMUL, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE,
              C_MAX, Q_ONE, -Q_ONE, 2 * Q_ONE);
        offer(FUNC_VMUL, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX);
        // Unused codes give zero whatever the operands hold.
        offer(FUNC_RSVD5, -1, -1, -1, -1, -1, -1, -1, -1);
        offer(FUNC_RSVD6, C_MAX, C_MIN, Q_ONE, 1, C_MAX, C_MIN, Q_ONE, 1);
        offer(FUNC_RSVD7, -1, -1, -1, -1, -1, -1, -1, -1);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i >= RANDOM_WORDS - 100)
                settle = 1'b1;
            if ($urandom_range(0, 15) == 0)
                op = 3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
            else
                op = 3'($urandom_range(FUNC_ADD, FUNC_VMUL));
            offer(op, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                  pick_comp(), pick_comp(), pick_comp(), pick_comp());
        end
        s_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d add, %0d subtract, %0d product, %0d conjugate, %0d vector",
                 op_count[FUNC_ADD], op_count[FUNC_SUB], op_count[FUNC_MUL],
                 op_count[FUNC_CONJ], op_count[FUNC_VMUL]);
        $display("words and %0d with unused codes; %0d results compared, %0d mismatches.",
                 op_count[FUNC_RSVD5] + op_count[FUNC_RSVD6] + op_count[FUNC_RSVD7],
                 results, fails);
        if (fails == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #400000;
        $display("Timed out with %0d results still outstanding.", outstanding);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/qau_pkg.sv
design/qau_mult.sv
design/qau_accum.sv
design/quaternion_arith_unit_top.sv
bench/quat_checker.sv
bench/tb.sv
